/* rtl/core/osu_pkg.sv */
// Operand stack unit: shared types, codes and defaults.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package osu_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 256;
  localparam int unsigned WORD_WIDTH_DEF  = 64;

  typedef enum logic [2:0] {
    K_PUSH   = 3'd0,
    K_POP    = 3'd1,
    K_PEEK   = 3'd2,
    K_SWAP   = 3'd3,
    K_DUP    = 3'd4,
    K_ROTATE = 3'd5,
    K_CLEAR  = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BOUNDS    = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] push_word;
    logic [7:0]  depth_a;
    logic [7:0]  depth_b;
    logic [8:0]  rotate_count;
  } in_word_t;

  typedef struct packed {
    logic [63:0] read_word;
    logic [1:0]  status;
    logic [8:0]  entry_count;
    logic        is_empty_flag;
    logic        is_full_flag;
  } out_word_t;

  typedef enum logic [2:0] {
    A_TOP,
    A_CNT,
    A_DA,
    A_DB,
    A_PTR,
    A_PTRP1,
    A_PTRM1
  } addr_sel_e;

  typedef enum logic [1:0] {
    W_PUSH,
    W_RDATA,
    W_TMP
  } wdata_sel_e;

  typedef enum logic [1:0] {
    C_HOLD,
    C_INC,
    C_DEC,
    C_CLR
  } cnt_op_e;

  typedef enum logic [1:0] {
    P_HOLD,
    P_TOP,
    P_DEC
  } ptr_op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_SWP_RB,
    S_SWP_WA,
    S_SWP_WB,
    S_DUP_W,
    S_ROT_LOAD,
    S_ROT_MOVE,
    S_ROT_LAST,
    S_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic       op_load;
    logic       status_ld;
    logic       word_ld;
    logic       tmp_ld;
    logic       rd_en;
    addr_sel_e  rd_sel;
    logic       wr_en;
    addr_sel_e  wr_sel;
    wdata_sel_e wdata_sel;
    cnt_op_e    cnt_op;
    ptr_op_e    ptr_op;
    logic       out_load;
  } osu_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       op_ok;
    logic       rot_go;
    logic       at_base;
  } osu_stat_t;

endpackage

`default_nettype wire

/* rtl/core/operand_stack_unit.sv */
// Operand stack unit top level: bounded LIFO of opaque words.
// Depends on osu_pkg, osu_ctrl and osu_dpath.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o   | in_word_i  (osu_pkg::in_word_t)
//   out     | output    | out_valid_o / out_stall_i | out_word_o (osu_pkg::out_word_t)
//
// One word in flight at a time; the entry memory gives one read and one write a cycle.
// Per word after accept: decode; pop and peek then READ, dup DUP_W, swap SWP_RB,
// SWP_WA, SWP_WB, rotate ROT_LOAD, ROT_MOVE to the base, ROT_LAST; all end in DONE.
// Reset empties the stack at once; no memory clearing pass.
// A stalled output word holds; the next input word is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module operand_stack_unit #(
  parameter int unsigned STACK_DEPTH = osu_pkg::STACK_DEPTH_DEF,
  parameter int unsigned WORD_WIDTH  = osu_pkg::WORD_WIDTH_DEF
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  osu_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output osu_pkg::out_word_t out_word_o
);
  import osu_pkg::*;

  osu_cmd_t  cmd;
  osu_stat_t stat;

  osu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  osu_dpath #(
    .STACK_DEPTH (STACK_DEPTH),
    .WORD_WIDTH  (WORD_WIDTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_word_o (out_word_o)
  );

endmodule

`default_nettype wire

/* rtl/core/osu_ctrl.sv */
// Operand stack unit controller: sequences each operation and the output word.
// Depends on osu_pkg; drives osu_dpath through osu_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module osu_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  input  osu_pkg::osu_stat_t  stat_i,
  output osu_pkg::osu_cmd_t   cmd_o
);
  import osu_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.rd_sel     = A_TOP;
    cmd_o.wr_sel     = A_CNT;
    cmd_o.wdata_sel  = W_PUSH;
    cmd_o.cnt_op     = C_HOLD;
    cmd_o.ptr_op     = P_HOLD;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op_load = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.status_ld = 1'b1;
        state_d         = S_DONE;
        case (kind_e'(stat_i.kind))
          K_PUSH: begin
            if (stat_i.op_ok) begin
              cmd_o.wr_en     = 1'b1;
              cmd_o.wr_sel    = A_CNT;
              cmd_o.wdata_sel = W_PUSH;
              cmd_o.cnt_op    = C_INC;
            end
          end
          K_POP: begin
            if (stat_i.op_ok) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = A_TOP;
              cmd_o.cnt_op = C_DEC;
              state_d      = S_READ;
            end
          end
          K_PEEK: begin
            if (stat_i.op_ok) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = A_DA;
              state_d      = S_READ;
            end
          end
          K_SWAP: begin
            if (stat_i.op_ok) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = A_DA;
              state_d      = S_SWP_RB;
            end
          end
          K_DUP: begin
            if (stat_i.op_ok) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = A_TOP;
              state_d      = S_DUP_W;
            end
          end
          K_ROTATE: begin
            if (stat_i.rot_go) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = A_TOP;
              cmd_o.ptr_op = P_TOP;
              state_d      = S_ROT_LOAD;
            end
          end
          K_CLEAR: begin
            cmd_o.cnt_op = C_CLR;
          end
          default: begin
          end
        endcase
      end
      S_READ: begin
        cmd_o.word_ld = 1'b1;
        state_d       = S_DONE;
      end
      S_SWP_RB: begin
        cmd_o.tmp_ld = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = A_DB;
        state_d      = S_SWP_WA;
      end
      S_SWP_WA: begin
        cmd_o.wr_en     = 1'b1;
        cmd_o.wr_sel    = A_DA;
        cmd_o.wdata_sel = W_RDATA;
        state_d         = S_SWP_WB;
      end
      S_SWP_WB: begin
        cmd_o.wr_en     = 1'b1;
        cmd_o.wr_sel    = A_DB;
        cmd_o.wdata_sel = W_TMP;
        state_d         = S_DONE;
      end
      S_DUP_W: begin
        cmd_o.wr_en     = 1'b1;
        cmd_o.wr_sel    = A_CNT;
        cmd_o.wdata_sel = W_RDATA;
        cmd_o.cnt_op    = C_INC;
        state_d         = S_DONE;
      end
      S_ROT_LOAD: begin
        cmd_o.tmp_ld = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = A_PTRM1;
        cmd_o.ptr_op = P_DEC;
        state_d      = S_ROT_MOVE;
      end
      S_ROT_MOVE: begin
        // rdata holds entry ptr; it moves up one place
        cmd_o.wr_en     = 1'b1;
        cmd_o.wr_sel    = A_PTRP1;
        cmd_o.wdata_sel = W_RDATA;
        if (stat_i.at_base) begin
          state_d = S_ROT_LAST;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = A_PTRM1;
          cmd_o.ptr_op = P_DEC;
        end
      end
      S_ROT_LAST: begin
        cmd_o.wr_en     = 1'b1;
        cmd_o.wr_sel    = A_PTR;
        cmd_o.wdata_sel = W_TMP;
        state_d         = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* rtl/core/osu_dpath.sv */
// Operand stack unit datapath: entry memory, count, checks and output word.
// Depends on osu_pkg; commanded by osu_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module osu_dpath #(
  parameter int unsigned STACK_DEPTH = osu_pkg::STACK_DEPTH_DEF,
  parameter int unsigned WORD_WIDTH  = osu_pkg::WORD_WIDTH_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  osu_pkg::in_word_t   in_word_i,
  input  osu_pkg::osu_cmd_t   cmd_i,
  output osu_pkg::osu_stat_t  stat_o,
  output osu_pkg::out_word_t  out_word_o
);
  import osu_pkg::*;

  localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned CMP_W  = (CNT_W > 9) ? CNT_W : 9;

  logic [WORD_WIDTH-1:0] mem_q [STACK_DEPTH];

  in_word_t              op_q;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  status_e               status_q, status_d;
  logic [WORD_WIDTH-1:0] word_q, rdata_q, tmp_q, wdata;
  logic [ADDR_W-1:0]     ptr_q, rd_addr, wr_addr;
  out_word_t             out_q;

  logic [CMP_W-1:0]  cnt_x, da_x, db_x, rn_x;
  logic [ADDR_W-1:0] a_top, a_cnt, a_da, a_db, a_base;
  logic              full, empty, da_bad, db_bad;

  assign cnt_x  = CMP_W'(cnt_q);
  assign da_x   = CMP_W'(op_q.depth_a);
  assign db_x   = CMP_W'(op_q.depth_b);
  assign rn_x   = CMP_W'(op_q.rotate_count);
  assign full   = (cnt_q == CNT_W'(STACK_DEPTH));
  assign empty  = (cnt_q == '0);
  assign da_bad = (da_x >= cnt_x);
  assign db_bad = (db_x >= cnt_x);

  assign a_top  = ADDR_W'(cnt_x - CMP_W'(1));
  assign a_cnt  = ADDR_W'(cnt_q);
  assign a_da   = ADDR_W'(cnt_x - CMP_W'(1) - da_x);
  assign a_db   = ADDR_W'(cnt_x - CMP_W'(1) - db_x);
  assign a_base = ADDR_W'(cnt_x - rn_x);

  always_comb begin
    status_d = ST_OK;
    case (kind_e'(op_q.kind))
      K_PUSH:  if (full) status_d = ST_OVERFLOW;
      K_POP:   if (empty) status_d = ST_UNDERFLOW;
      K_PEEK:  if (da_bad) status_d = ST_BOUNDS;
      K_SWAP:  if (da_bad || db_bad) status_d = ST_BOUNDS;
      K_DUP: begin
        if (empty) begin
          status_d = ST_UNDERFLOW;
        end else if (full) begin
          status_d = ST_OVERFLOW;
        end
      end
      default: status_d = ST_OK;
    endcase
  end

  assign stat_o.kind    = op_q.kind;
  assign stat_o.op_ok   = (status_d == ST_OK);
  assign stat_o.rot_go  = (rn_x > CMP_W'(1)) && (rn_x <= cnt_x);
  assign stat_o.at_base = (ptr_q == a_base);

  always_comb begin
    case (cmd_i.rd_sel)
      A_TOP:   rd_addr = a_top;
      A_CNT:   rd_addr = a_cnt;
      A_DA:    rd_addr = a_da;
      A_DB:    rd_addr = a_db;
      A_PTR:   rd_addr = ptr_q;
      A_PTRP1: rd_addr = ptr_q + ADDR_W'(1);
      A_PTRM1: rd_addr = ptr_q - ADDR_W'(1);
      default: rd_addr = a_top;
    endcase
  end

  always_comb begin
    case (cmd_i.wr_sel)
      A_TOP:   wr_addr = a_top;
      A_CNT:   wr_addr = a_cnt;
      A_DA:    wr_addr = a_da;
      A_DB:    wr_addr = a_db;
      A_PTR:   wr_addr = ptr_q;
      A_PTRP1: wr_addr = ptr_q + ADDR_W'(1);
      A_PTRM1: wr_addr = ptr_q - ADDR_W'(1);
      default: wr_addr = a_cnt;
    endcase
  end

  always_comb begin
    case (cmd_i.wdata_sel)
      W_PUSH:  wdata = op_q.push_word[WORD_WIDTH-1:0];
      W_RDATA: wdata = rdata_q;
      W_TMP:   wdata = tmp_q;
      default: wdata = op_q.push_word[WORD_WIDTH-1:0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    case (cmd_i.cnt_op)
      C_INC:   cnt_d = cnt_q + CNT_W'(1);
      C_DEC:   cnt_d = cnt_q - CNT_W'(1);
      C_CLR:   cnt_d = '0;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op_load) begin
      op_q <= in_word_i;
    end
    if (cmd_i.status_ld) begin
      status_q <= status_d;
      word_q   <= '0;
    end else if (cmd_i.word_ld) begin
      word_q <= rdata_q;
    end
    if (cmd_i.tmp_ld) begin
      tmp_q <= rdata_q;
    end
    case (cmd_i.ptr_op)
      P_TOP:   ptr_q <= a_top;
      P_DEC:   ptr_q <= ptr_q - ADDR_W'(1);
      default: ptr_q <= ptr_q;
    endcase
    if (cmd_i.out_load) begin
      out_q.read_word     <= 64'(word_q);
      out_q.status        <= status_q;
      out_q.entry_count   <= cnt_x[8:0];
      out_q.is_empty_flag <= empty;
      out_q.is_full_flag  <= full;
    end
  end

  assign out_word_o = out_q;

endmodule

`default_nettype wire

/* dv/tb_operand_stack_unit.sv */
// Self-checking testbench for operand_stack_unit: directed corner cases, a fill to
// full, then biased random phases of mixed kinds with random gaps and output stalls.
// Depends on osu_pkg and the operand_stack_unit RTL.
`timescale 1ns / 1ps

module tb_operand_stack_unit;
  import osu_pkg::*;

  localparam int DEPTH = STACK_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int TAIL_CYCLES = DEPTH + 40;
  localparam logic [2:0] KIND_UNUSED = 3'd7;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  in_word_t  in_word = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_word_t out_word;

  logic [63:0] model_entries [DEPTH];
  int          model_count = 0;
  out_word_t   expected_results [$];
  bit          idle_on = 1'b0;
  int          mismatches = 0;
  int          cycles = 0;
  int          checked = 0;
  int          kind_seen [8];
  int          status_seen [4];
  int          stall_left = 0;

  operand_stack_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles,
               expected_results.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= 50)
      $display("mismatch %0d at cycle %0d: %s got %0h expected %0h", mismatches, cycles,
               what, got, want);
  endtask

  function automatic out_word_t stack_predict(in_word_t w);
    out_word_t   r;
    int          top;
    int          base;
    int          ia;
    int          ib;
    logic [63:0] t;
    r = '0;
    r.status = ST_OK;
    case (w.kind)
      K_PUSH: begin
        if (model_count >= DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          model_entries[model_count] = w.push_word;
          model_count++;
        end
      end
      K_POP: begin
        if (model_count == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          model_count--;
          r.read_word = model_entries[model_count];
        end
      end
      K_PEEK: begin
        if (int'(w.depth_a) >= model_count) r.status = ST_BOUNDS;
        else r.read_word = model_entries[model_count - 1 - int'(w.depth_a)];
      end
      K_SWAP: begin
        if (int'(w.depth_a) >= model_count || int'(w.depth_b) >= model_count) begin
          r.status = ST_BOUNDS;
        end else begin
          ia = model_count - 1 - int'(w.depth_a);
          ib = model_count - 1 - int'(w.depth_b);
          t = model_entries[ia];
          model_entries[ia] = model_entries[ib];
          model_entries[ib] = t;
        end
      end
      K_DUP: begin
        if (model_count == 0) begin
          r.status = ST_UNDERFLOW;
        end else if (model_count >= DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          model_entries[model_count] = model_entries[model_count - 1];
          model_count++;
        end
      end
      K_ROTATE: begin
        if (int'(w.rotate_count) > 1 && int'(w.rotate_count) <= model_count) begin
          top = model_count - 1;
          base = model_count - int'(w.rotate_count);
          t = model_entries[top];
          for (int i = top; i > base; i--) model_entries[i] = model_entries[i - 1];
          model_entries[base] = t;
        end
      end
      K_CLEAR: model_count = 0;
      default: ;
    endcase
    r.entry_count = 9'(model_count);
    r.is_empty_flag = (model_count == 0);
    r.is_full_flag = (model_count >= DEPTH);
    kind_seen[w.kind]++;
    status_seen[r.status]++;
    return r;
  endfunction

  // result checker and output stall generator
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      checked++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected word", out_word.read_word, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_word.read_word !== want.read_word)
          report_mismatch("read_word", out_word.read_word, want.read_word);
        if (out_word.status !== want.status)
          report_mismatch("status", 64'(out_word.status), 64'(want.status));
        if (out_word.entry_count !== want.entry_count)
          report_mismatch("entry_count", 64'(out_word.entry_count), 64'(want.entry_count));
        if (out_word.is_empty_flag !== want.is_empty_flag)
          report_mismatch("is_empty_flag", 64'(out_word.is_empty_flag),
                          64'(want.is_empty_flag));
        if (out_word.is_full_flag !== want.is_full_flag)
          report_mismatch("is_full_flag", 64'(out_word.is_full_flag),
                          64'(want.is_full_flag));
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_stall <= 1'b0;
    end
  end

  task automatic issue_op(in_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(stack_predict(w));
  endtask

  task automatic issue(logic [2:0] kind, logic [63:0] word = '0, logic [7:0] da = '0,
                       logic [7:0] db = '0, logic [8:0] rn = '0);
    in_word_t w;
    w.kind = kind;
    w.push_word = word;
    w.depth_a = da;
    w.depth_b = db;
    w.rotate_count = rn;
    issue_op(w);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] random_word();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [7:0] pick_depth();
    if (model_count > 0 && $urandom_range(0, 99) < 85)
      return 8'($urandom_range(0, model_count - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [8:0] pick_rotate();
    if (model_count >= 2 && $urandom_range(0, 99) < 75)
      return 9'($urandom_range(2, model_count));
    return 9'($urandom_range(0, 511));
  endfunction

  function automatic in_word_t random_op(int grow_pct);
    in_word_t w;
    int       r;
    w.push_word = random_word();
    w.depth_a = pick_depth();
    w.depth_b = pick_depth();
    w.rotate_count = pick_rotate();
    r = $urandom_range(0, 99);
    if (r < 10) begin
      w.kind = 3'($urandom_range(0, 7));
      w.depth_a = 8'($urandom_range(0, 255));
      w.rotate_count = 9'($urandom_range(0, 511));
    end else if ($urandom_range(0, 99) < grow_pct) begin
      w.kind = ($urandom_range(0, 3) == 0) ? K_DUP : K_PUSH;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 30) w.kind = K_POP;
      else if (r < 52) w.kind = K_PEEK;
      else if (r < 72) w.kind = K_SWAP;
      else if (r < 94) w.kind = K_ROTATE;
      else if (r < 98) w.kind = KIND_UNUSED;
      else w.kind = K_CLEAR;
    end
    return w;
  endfunction

  task automatic test_empty_stack();
    idle_on = 1'b0;
    issue(K_POP);
    issue(K_PEEK, '0, 8'd0);
    issue(K_DUP);
    issue(K_SWAP, '0, 8'd0, 8'd0);
    issue(K_ROTATE, '0, 8'd0, 8'd0, 9'd0);
    issue(KIND_UNUSED, '1, 8'hff, 8'hff, 9'h1ff);
    issue(K_CLEAR);
  endtask

  task automatic test_basic_ops();
    idle_on = 1'b1;
    issue(K_PUSH, 64'h0);
    issue(K_PUSH, '1);
    issue(K_PUSH, 64'h0123_4567_89ab_cdef);
    issue(K_PUSH, 64'hfedc_ba98_7654_3210);
    issue(K_PEEK, '0, 8'd0);
    issue(K_PEEK, '0, 8'd3);
    issue(K_PEEK, '0, 8'd4);
    issue(K_PEEK, '0, 8'hff);
    issue(K_SWAP, '0, 8'd0, 8'd3);
    issue(K_SWAP, '0, 8'd1, 8'd1);
    issue(K_SWAP, '0, 8'd2, 8'd4);
    issue(K_DUP);
    issue(K_ROTATE, '0, 8'd0, 8'd0, 9'd3);
    issue(K_ROTATE, '0, 8'd0, 8'd0, 9'd1);
    issue(K_ROTATE, '0, 8'd0, 8'd0, 9'd6);
    issue(K_ROTATE, '0, 8'd0, 8'd0, 9'd5);
    issue(K_POP);
    issue(K_CLEAR);
  endtask

  task automatic test_fill_to_full();
    idle_on = 1'b1;
    while (model_count < DEPTH) begin
      if (model_count > 0 && $urandom_range(0, 4) == 0) issue(K_DUP);
      else issue(K_PUSH, random_word());
    end
    issue(K_PUSH, random_word());
    issue(K_DUP);
    issue(K_PEEK, '0, 8'hff);
    issue(K_SWAP, '0, 8'd0, 8'hff);
    issue(K_ROTATE, '0, 8'd0, 8'd0, 9'd256);
    issue(K_ROTATE, '0, 8'd0, 8'd0, 9'd257);
    issue(K_POP);
  endtask

  task automatic test_random_mix(int rounds, int per_round);
    for (int k = 0; k < rounds; k++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < per_round; n++)
        issue_op(random_op((k % 2 == 0) ? 40 : 62));
      if (k == rounds / 2) wait_drained();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_stack();
    test_basic_ops();
    test_fill_to_full();
    test_random_mix(10, 106);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d words checked; push %0d pop %0d peek %0d swap %0d dup %0d rotate %0d",
             checked, kind_seen[K_PUSH], kind_seen[K_POP], kind_seen[K_PEEK],
             kind_seen[K_SWAP], kind_seen[K_DUP], kind_seen[K_ROTATE]);
    $display("clear %0d unused %0d; ok %0d overflow %0d underflow %0d bounds %0d",
             kind_seen[K_CLEAR], kind_seen[KIND_UNUSED], status_seen[ST_OK],
             status_seen[ST_OVERFLOW], status_seen[ST_UNDERFLOW], status_seen[ST_BOUNDS]);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
